// ===== rtl/bdeq_pkg.sv =====
// ----------------------------------------------------------------------------
// bdeq_pkg
// Shared widths, command and status codes for the bounded deque.
// ----------------------------------------------------------------------------
package bdeq_pkg;

   localparam int unsigned DEPTH_DEFAULT = 64;

   localparam int unsigned CMD_W    = 3;
   localparam int unsigned ELEM_W   = 32;
   localparam int unsigned STATUS_W = 2;

   // stream payloads, padded to whole bytes
   localparam int unsigned REQ_TDATA_W = ((CMD_W + ELEM_W + 7) / 8) * 8;
   localparam int unsigned RSP_TDATA_W = ((STATUS_W + ELEM_W + 7) / 8) * 8;

   localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd0;
   localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd1;
   localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd2;
   localparam logic [CMD_W-1:0] CMD_POP_BACK   = 3'd3;
   localparam logic [CMD_W-1:0] CMD_DUMP       = 3'd4;

   localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd2;

endpackage

// ===== rtl/bdeq_ram.sv =====
// ----------------------------------------------------------------------------
// bdeq_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module bdeq_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/bounded_double_ended_queue.sv =====
// ----------------------------------------------------------------------------
// bounded_double_ended_queue
// Double-ended queue of signed 32-bit values in a ring held in one RAM.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one command beat: push front, push back, pop front, pop back
//   or dump, plus the value to push. rsp_* returns result beats: status, the
//   removed or dumped element, and tlast on the final beat of a command.
//   Every push and pop gives one beat; a dump gives one beat per stored
//   element, front to back (a single empty beat if the queue is empty).
//   Codes 5 to 7 are swallowed without a result.
// Flow:
//   push: slot RAM written (unless full) and result registered at accept.
//   pop : the registered read of the slot RAM, then the result register.
//   dump: one RAM read per element, streamed through the result register.
//   One command is worked on at a time; req_tready is high only in idle
//   while the result register is empty or being drained.
// Reset: front index and count clear to zero (queue empty), result register
//   empties. RAM contents are not cleared; only written slots are ever read.
// Stall: a held rsp beat freezes the block; a dump resumes where it stopped.
// ----------------------------------------------------------------------------
module bounded_double_ended_queue #(
   parameter int unsigned DEPTH = bdeq_pkg::DEPTH_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   // req_tdata: [2:0] command, [34:3] value, rest zero
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [bdeq_pkg::REQ_TDATA_W-1:0] req_tdata,
   // rsp_tdata: [1:0] status, [33:2] element, rest zero
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [bdeq_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   output logic                             rsp_tlast
);

   import bdeq_pkg::*;

   localparam int unsigned AW = $clog2(DEPTH);     // slot index
   localparam int unsigned CW = $clog2(DEPTH + 1); // element count 0..DEPTH
   localparam logic [AW-1:0] LAST_IDX  = AW'(DEPTH - 1);
   localparam logic [CW-1:0] FULL_CNT  = CW'(DEPTH);
   localparam logic [CW:0]   DEPTH_EXT = (CW + 1)'(DEPTH);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_POP  = 3'b010,   // waiting on the RAM read for a pop
      ST_DUMP = 3'b100    // streaming stored elements out
   } state_type;

   // ---------------------------------------------------------------- request
   logic [CMD_W-1:0]         req_command;
   logic signed [ELEM_W-1:0] req_value;

   assign req_command = req_tdata[CMD_W-1:0];
   assign req_value   = req_tdata[CMD_W+ELEM_W-1:CMD_W];

   // ---------------------------------------------------------------- state
   state_type state_ff, state_in;
   logic [AW-1:0] front_ff, front_in;
   logic [CW-1:0] occ_ff, occ_in;
   logic [AW-1:0] dump_idx_ff, dump_idx_in;   // next slot to read in a dump
   logic [CW-1:0] dump_left_ff, dump_left_in; // beats still owed by a dump

   logic                       rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]        rsp_status_ff, rsp_status_in;
   logic signed [ELEM_W-1:0]   rsp_element_ff, rsp_element_in;
   logic                       rsp_last_ff, rsp_last_in;

   // ---------------------------------------------------------------- RAM port
   logic              wr_en, rd_en;
   logic [AW-1:0]     wr_addr, rd_addr;
   logic [ELEM_W-1:0] rd_data;

   bdeq_ram #(
      .WIDTH (ELEM_W),
      .DEPTH (DEPTH)
   ) u_slots (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_value),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // ---------------------------------------------------------------- ring math
   // All wraps are explicit compares (select or subtract), so DEPTH need not be a power of two.
   logic [AW-1:0] front_dec, front_inc, dump_inc, tail_idx, back_idx;
   logic [CW:0]   tail_sum, back_sum;

   always_comb begin
      front_dec = (front_ff == '0) ? LAST_IDX : front_ff - 1'b1;
      front_inc = (front_ff == LAST_IDX) ? '0 : front_ff + 1'b1;
      dump_inc  = (dump_idx_ff == LAST_IDX) ? '0 : dump_idx_ff + 1'b1;
      tail_sum  = (CW + 1)'(front_ff) + (CW + 1)'(occ_ff);
      back_sum  = tail_sum - 1'b1;   // only used while occ_ff > 0
      tail_idx  = (tail_sum >= DEPTH_EXT) ? AW'(tail_sum - DEPTH_EXT) : AW'(tail_sum);
      back_idx  = (back_sum >= DEPTH_EXT) ? AW'(back_sum - DEPTH_EXT) : AW'(back_sum);
   end

   // ---------------------------------------------------------------- control
   logic out_free, is_full, is_empty;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign is_full    = (occ_ff == FULL_CNT);
   assign is_empty   = (occ_ff == '0);
   assign req_tready = (state_ff == ST_IDLE) && out_free;

   // A push writes on its accept edge, before any later command can read,
   // so read-after-write needs no forwarding.
   always_comb begin
      state_in       = state_ff;
      front_in       = front_ff;
      occ_in         = occ_ff;
      dump_idx_in    = dump_idx_ff;
      dump_left_in   = dump_left_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;
      rsp_status_in  = rsp_status_ff;
      rsp_element_in = rsp_element_ff;
      rsp_last_in    = rsp_last_ff;
      wr_en          = 1'b0;
      wr_addr        = tail_idx;
      rd_en          = 1'b0;
      rd_addr        = front_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid && req_tready) begin
               case (req_command)
                  CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
                     rsp_valid_in   = 1'b1;
                     rsp_element_in = '0;
                     rsp_last_in    = 1'b1;
                     if (is_full) begin
                        rsp_status_in = STAT_FULL;
                     end else begin
                        rsp_status_in = STAT_OK;
                        wr_en         = 1'b1;
                        occ_in        = occ_ff + 1'b1;
                        if (req_command == CMD_PUSH_FRONT) begin
                           wr_addr  = front_dec;
                           front_in = front_dec;
                        end
                     end
                  end
                  CMD_POP_FRONT, CMD_POP_BACK: begin
                     if (is_empty) begin
                        rsp_valid_in   = 1'b1;
                        rsp_status_in  = STAT_EMPTY;
                        rsp_element_in = '0;
                        rsp_last_in    = 1'b1;
                     end else begin
                        rd_en    = 1'b1;
                        occ_in   = occ_ff - 1'b1;
                        state_in = ST_POP;
                        if (req_command == CMD_POP_FRONT) begin
                           front_in = front_inc;
                        end else begin
                           rd_addr = back_idx;
                        end
                     end
                  end
                  CMD_DUMP: begin
                     if (is_empty) begin
                        rsp_valid_in   = 1'b1;
                        rsp_status_in  = STAT_EMPTY;
                        rsp_element_in = '0;
                        rsp_last_in    = 1'b1;
                     end else begin
                        rd_en        = 1'b1;
                        dump_idx_in  = front_inc;
                        dump_left_in = occ_ff;
                        state_in     = ST_DUMP;
                     end
                  end
                  default: ;   // unused codes: no result
               endcase
            end
         end
         ST_POP: begin
            // result register is empty here: nothing was loaded at accept
            rsp_valid_in   = 1'b1;
            rsp_status_in  = STAT_OK;
            rsp_element_in = rd_data;
            rsp_last_in    = 1'b1;
            state_in       = ST_IDLE;
         end
         ST_DUMP: begin
            if (out_free) begin
               rsp_valid_in   = 1'b1;
               rsp_status_in  = STAT_OK;
               rsp_element_in = rd_data;
               rsp_last_in    = (dump_left_ff == CW'(1));
               if (dump_left_ff == CW'(1)) begin
                  state_in = ST_IDLE;
               end else begin
                  rd_en        = 1'b1;
                  rd_addr      = dump_idx_ff;
                  dump_idx_in  = dump_inc;
                  dump_left_in = dump_left_ff - 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // ---------------------------------------------------------------- registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         front_ff     <= '0;
         occ_ff       <= '0;
         dump_idx_ff  <= '0;
         dump_left_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         front_ff     <= front_in;
         occ_ff       <= occ_in;
         dump_idx_ff  <= dump_idx_in;
         dump_left_ff <= dump_left_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_status_ff  <= rsp_status_in;
      rsp_element_ff <= rsp_element_in;
      rsp_last_ff    <= rsp_last_in;
   end

   // ---------------------------------------------------------------- response
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_TDATA_W'({rsp_element_ff, rsp_status_ff});
   assign rsp_tlast  = rsp_last_ff;

endmodule
